[hw/rtl/bsp_pkg.sv]
// Shared types and constants for the B-spline curve point evaluator.
// Used by every module under hw/rtl; depends on nothing else.

package bsp_pkg;

	// Default sizing of the knot and control point stores.
	localparam int DEF_MAX_KNOTS  = 64;
	localparam int DEF_MAX_DEGREE = 7;

	// Field widths.
	localparam int OP_W    = 2;
	localparam int INDEX_W = 6;
	localparam int U_W     = 24;   // unsigned Q8.16
	localparam int COORD_W = 32;   // signed Q16.16
	localparam int SPAN_W  = 6;
	localparam int DEG_W   = 3;
	localparam int KC_W    = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// Internal arithmetic widths.
	localparam int LR_W   = U_W + 1;          // knot differences
	localparam int DEN_W  = LR_W + 1;         // sum of two differences
	localparam int NB_W   = 32;               // basis value, Q2.30
	localparam int PROD_W = LR_W + NB_W;      // difference times basis value
	localparam int MAG_W  = PROD_W - 1;       // magnitude of that product
	localparam int ACC_W  = 64;

	localparam logic signed [NB_W-1:0]  ONE_Q30 = 32'sh4000_0000;
	localparam logic signed [ACC_W-1:0] ACC_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

	// Operation codes of an input word.
	localparam logic [OP_W-1:0] OP_KNOT  = 2'd0;
	localparam logic [OP_W-1:0] OP_POINT = 2'd1;
	localparam logic [OP_W-1:0] OP_EVAL  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT = 1'b1;

	// Per-cycle commands from the controller to the datapath.
	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_RD_LO,
		CMD_RD_HI,
		CMD_SPAN_END,
		CMD_SRCH_INIT,
		CMD_RD_MID,
		CMD_SRCH_UPD,
		CMD_SPAN_LO,
		CMD_BASIS_INIT,
		CMD_RD_LEFT,
		CMD_RD_RIGHT,
		CMD_SET_RIGHT,
		CMD_DEN,
		CMD_MUL_R,
		CMD_MUL_L,
		CMD_DIV_START,
		CMD_NB_UPD,
		CMD_NB_TOP,
		CMD_MAC_INIT,
		CMD_RD_PT,
		CMD_MAC_X,
		CMD_MAC_Y,
		CMD_MAC_Z,
		CMD_FINISH,
		CMD_FAIL
	} dp_cmd_t;

	// Status flags from the datapath to the controller.
	typedef struct packed {
		logic cfg_bad;
		logic u_lt;
		logic u_gt;
		logic u_eq;
		logic srch_done;
		logic r_last;
		logic j_last;
		logic k_last;
		logic div_done;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHK,
		S_LO,
		S_HI,
		S_SRCH,
		S_SCMP,
		S_BINIT,
		S_RDL,
		S_RDR,
		S_SETR,
		S_DEN,
		S_MULR,
		S_MULL,
		S_DIVS,
		S_DIVW,
		S_NBTOP,
		S_MINIT,
		S_RDPT,
		S_MX,
		S_MY,
		S_MZ,
		S_EMIT
	} ctl_state_t;

endpackage

[hw/rtl/bsp_if.sv]
// Valid/ready channel interfaces for input words and result words.
// Depends on bsp_pkg for the field widths.

interface bsp_item_if import bsp_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic [INDEX_W-1:0]        index;
	logic [U_W-1:0]            knot_value;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic [U_W-1:0]            param_u;

	modport source(output valid, op, index, knot_value, point_x, point_y, point_z, param_u,
		input ready);
	modport sink(input valid, op, index, knot_value, point_x, point_y, point_z, param_u,
		output ready);
endinterface

interface bsp_result_if import bsp_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic                      status;
	logic [SPAN_W-1:0]         span;
	logic signed [COORD_W-1:0] curve_x;
	logic signed [COORD_W-1:0] curve_y;
	logic signed [COORD_W-1:0] curve_z;

	modport source(output valid, status, span, curve_x, curve_y, curve_z, input ready);
	modport sink(input valid, status, span, curve_x, curve_y, curve_z, output ready);
endinterface

[hw/rtl/bsp_div.sv]
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on bsp_pkg for the operand widths.

module bsp_div import bsp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [PROD_W-1:0] num_a,
	input  logic signed [PROD_W-1:0] num_b,
	input  logic signed [DEN_W-1:0]  den,
	output logic                     done,
	output logic signed [PROD_W-1:0] quo_a,
	output logic signed [PROD_W-1:0] quo_b
);

	localparam int CW = $clog2(MAG_W);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	logic [MAG_W-1:0] qa_q, qb_q;
	logic [DEN_W-1:0] ra_q, rb_q;
	logic [DEN_W-1:0] dm_q;
	logic            nega_q, negb_q;

	logic [DEN_W:0]   ta, tb;
	logic [DEN_W-1:0] den_mag;
	logic [PROD_W-1:0] a_abs, b_abs;

	always_comb begin
		den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
		a_abs   = num_a[PROD_W-1] ? PROD_W'(-num_a) : PROD_W'(num_a);
		b_abs   = num_b[PROD_W-1] ? PROD_W'(-num_b) : PROD_W'(num_b);
		ta      = {ra_q, qa_q[MAG_W-1]};
		tb      = {rb_q, qb_q[MAG_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(MAG_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qa_q   <= a_abs[MAG_W-1:0];
			qb_q   <= b_abs[MAG_W-1:0];
			ra_q   <= '0;
			rb_q   <= '0;
			dm_q   <= den_mag;
			nega_q <= num_a[PROD_W-1] ^ den[DEN_W-1];
			negb_q <= num_b[PROD_W-1] ^ den[DEN_W-1];
		end else if (busy_q) begin
			if (ta >= {1'b0, dm_q}) begin
				ra_q <= DEN_W'(ta - {1'b0, dm_q});
				qa_q <= {qa_q[MAG_W-2:0], 1'b1};
			end else begin
				ra_q <= ta[DEN_W-1:0];
				qa_q <= {qa_q[MAG_W-2:0], 1'b0};
			end
			if (tb >= {1'b0, dm_q}) begin
				rb_q <= DEN_W'(tb - {1'b0, dm_q});
				qb_q <= {qb_q[MAG_W-2:0], 1'b1};
			end else begin
				rb_q <= tb[DEN_W-1:0];
				qb_q <= {qb_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done  = done_q;
	assign quo_a = nega_q ? -$signed({1'b0, qa_q}) : $signed({1'b0, qa_q});
	assign quo_b = negb_q ? -$signed({1'b0, qb_q}) : $signed({1'b0, qb_q});

endmodule

[hw/rtl/bsp_dp.sv]
// Datapath: configuration registers, knot and point stores, span search
// indexes, basis triangle registers, multiplier, divider and accumulators.
// Depends on bsp_pkg and bsp_div.

module bsp_dp import bsp_pkg::*; #(
	parameter int MAX_KNOTS  = DEF_MAX_KNOTS,
	parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic [OP_W-1:0]           op,
	input  logic [INDEX_W-1:0]        index,
	input  logic [U_W-1:0]            knot_value,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] point_z,
	input  logic [U_W-1:0]            param_u,
	input  dp_cmd_t                   cmd,
	output dp_stat_t                  stat,
	output logic                      status,
	output logic [SPAN_W-1:0]         span,
	output logic signed [COORD_W-1:0] curve_x,
	output logic signed [COORD_W-1:0] curve_y,
	output logic signed [COORD_W-1:0] curve_z
);

	localparam int AW  = $clog2(MAX_KNOTS);
	localparam int IW  = ((AW > KC_W) ? AW : KC_W) + 1;
	localparam int NBN = MAX_DEGREE + 1;
	localparam int JW  = $clog2(NBN);

	function automatic logic signed [NB_W-1:0] sat_nb(input logic signed [PROD_W:0] v);
		if (v > 58'sd2147483647)
			sat_nb = 32'sh7FFF_FFFF;
		else if (v < -58'sd2147483648)
			sat_nb = 32'sh8000_0000;
		else
			sat_nb = v[NB_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		if (v > ACC_LIM)
			sat_acc = ACC_LIM;
		else if (v < -ACC_LIM)
			sat_acc = -ACC_LIM;
		else
			sat_acc = v;
	endfunction

	function automatic logic signed [COORD_W-1:0] round_out(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] v;
		v = (ACC_W+1)'(a) + 65'sd536870912;
		v = v >>> 30;
		if (v > 65'sd2147483647)
			round_out = 32'sh7FFF_FFFF;
		else if (v < -65'sd2147483648)
			round_out = 32'sh8000_0000;
		else
			round_out = v[COORD_W-1:0];
	endfunction

	// Configuration.
	logic [DEG_W-1:0] degree_q;
	logic [KC_W-1:0]  knot_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q     <= DEG_W'(3);
			knot_count_q <= KC_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEGREE:     degree_q <= cfg_data[DEG_W-1:0];
				CFG_KNOT_COUNT: knot_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stores.
	logic [U_W-1:0]            knot_mem [MAX_KNOTS];
	logic signed [COORD_W-1:0] px_mem [MAX_KNOTS];
	logic signed [COORD_W-1:0] py_mem [MAX_KNOTS];
	logic signed [COORD_W-1:0] pz_mem [MAX_KNOTS];

	logic [IW-1:0] idx_ext, p_ext, ncp, mid, kra, pra;
	logic          idx_ok;

	logic [U_W-1:0]            u_q, rd_q;
	logic signed [COORD_W-1:0] px_q, py_q, pz_q;
	logic [IW-1:0]             lo_q, hi_q, s_q;
	logic [JW-1:0]             j_q, r_q, k_q;

	assign idx_ext = IW'(index);
	assign idx_ok  = idx_ext < IW'(MAX_KNOTS);
	assign p_ext   = IW'(degree_q);
	assign ncp     = IW'(knot_count_q) - p_ext - IW'(1);
	assign mid     = IW'((({1'b0, lo_q} + {1'b0, hi_q}) >> 1));

	always_comb begin
		case (cmd)
			CMD_RD_LO:    kra = p_ext;
			CMD_RD_HI:    kra = ncp;
			CMD_RD_MID:   kra = mid;
			CMD_RD_LEFT:  kra = s_q + IW'(1) - IW'(j_q);
			CMD_RD_RIGHT: kra = s_q + IW'(j_q);
			default:      kra = '0;
		endcase
		pra = s_q - p_ext + IW'(k_q);
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_ACCEPT && idx_ok) begin
			if (op == OP_KNOT)
				knot_mem[idx_ext[AW-1:0]] <= knot_value;
			if (op == OP_POINT) begin
				px_mem[idx_ext[AW-1:0]] <= point_x;
				py_mem[idx_ext[AW-1:0]] <= point_y;
				pz_mem[idx_ext[AW-1:0]] <= point_z;
			end
		end
		rd_q <= knot_mem[kra[AW-1:0]];
		px_q <= px_mem[pra[AW-1:0]];
		py_q <= py_mem[pra[AW-1:0]];
		pz_q <= pz_mem[pra[AW-1:0]];
	end

	// Basis triangle registers.
	logic signed [LR_W-1:0]   lft_q [NBN];
	logic signed [LR_W-1:0]   rgt_q [NBN];
	logic signed [NB_W-1:0]   nb_q [NBN];
	logic signed [DEN_W-1:0]  den_q;
	logic signed [PROD_W-1:0] prod_r_q, prod_l_q, carry_q;
	logic signed [ACC_W-1:0]  acc_x_q, acc_y_q, acc_z_q;

	logic [JW-1:0]            nb_ra;
	logic signed [NB_W-1:0]   nb_rd;
	logic signed [LR_W-1:0]   rgt_rd, lft_rd, mul_a;
	logic signed [LR_W-1:0]   lft_new, rgt_new;
	logic signed [PROD_W-1:0] prod;
	logic signed [COORD_W-1:0] pt_sel;
	logic signed [ACC_W-1:0]  acc_sel, mac_prod, mac_sum;
	logic signed [PROD_W-1:0] qr, ql, qr_z, ql_z;
	logic                     div_done;

	always_comb begin
		nb_ra   = (cmd == CMD_MAC_X || cmd == CMD_MAC_Y || cmd == CMD_MAC_Z) ? k_q : r_q;
		nb_rd   = nb_q[nb_ra];
		rgt_rd  = rgt_q[r_q + JW'(1)];
		lft_rd  = lft_q[j_q - r_q];
		mul_a   = (cmd == CMD_MUL_L) ? lft_rd : rgt_rd;
		prod    = PROD_W'(mul_a) * PROD_W'(nb_rd);
		lft_new = $signed({1'b0, u_q}) - $signed({1'b0, rd_q});
		rgt_new = $signed({1'b0, rd_q}) - $signed({1'b0, u_q});
		case (cmd)
			CMD_MAC_Y: begin
				pt_sel  = py_q;
				acc_sel = acc_y_q;
			end
			CMD_MAC_Z: begin
				pt_sel  = pz_q;
				acc_sel = acc_z_q;
			end
			default: begin
				pt_sel  = px_q;
				acc_sel = acc_x_q;
			end
		endcase
		mac_prod = sat_acc(ACC_W'(nb_rd) * ACC_W'(pt_sel));
		mac_sum  = sat_acc(acc_sel + mac_prod);
		// A zero denominator makes both terms of the step zero.
		qr_z = (den_q == '0) ? '0 : qr;
		ql_z = (den_q == '0) ? '0 : ql;
	end

	bsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd == CMD_DIV_START),
		.num_a  (prod_r_q),
		.num_b  (prod_l_q),
		.den    (den_q),
		.done   (div_done),
		.quo_a  (qr),
		.quo_b  (ql)
	);

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				if (op == OP_EVAL)
					u_q <= param_u;
			end
			CMD_SPAN_END:  s_q <= ncp - IW'(1);
			CMD_SRCH_INIT: begin
				lo_q <= p_ext;
				hi_q <= ncp;
			end
			CMD_SRCH_UPD: begin
				if (u_q < rd_q)
					hi_q <= mid;
				else
					lo_q <= mid;
			end
			CMD_SPAN_LO:    s_q <= lo_q;
			CMD_BASIS_INIT: begin
				nb_q[0] <= ONE_Q30;
				j_q     <= JW'(1);
			end
			CMD_RD_RIGHT:  lft_q[j_q] <= lft_new;
			CMD_SET_RIGHT: begin
				rgt_q[j_q] <= rgt_new;
				r_q        <= '0;
				carry_q    <= '0;
			end
			CMD_DEN:   den_q <= DEN_W'(rgt_rd) + DEN_W'(lft_rd);
			CMD_MUL_R: prod_r_q <= prod;
			CMD_MUL_L: prod_l_q <= prod;
			CMD_NB_UPD: begin
				nb_q[r_q] <= sat_nb((PROD_W+1)'(carry_q) + (PROD_W+1)'(qr_z));
				carry_q   <= ql_z;
				r_q       <= r_q + JW'(1);
			end
			CMD_NB_TOP: begin
				nb_q[j_q] <= sat_nb((PROD_W+1)'(carry_q));
				j_q       <= j_q + JW'(1);
			end
			CMD_MAC_INIT: begin
				acc_x_q <= '0;
				acc_y_q <= '0;
				acc_z_q <= '0;
				k_q     <= '0;
			end
			CMD_MAC_X: acc_x_q <= mac_sum;
			CMD_MAC_Y: acc_y_q <= mac_sum;
			CMD_MAC_Z: begin
				acc_z_q <= mac_sum;
				k_q     <= k_q + JW'(1);
			end
			CMD_FINISH: begin
				status  <= 1'b0;
				span    <= SPAN_W'(s_q);
				curve_x <= round_out(acc_x_q);
				curve_y <= round_out(acc_y_q);
				curve_z <= round_out(acc_z_q);
			end
			CMD_FAIL: begin
				status  <= 1'b1;
				span    <= '0;
				curve_x <= '0;
				curve_y <= '0;
				curve_z <= '0;
			end
			default: ;
		endcase
	end

	// Status toward the controller.
	always_comb begin
		int p_i;
		int kc_i;
		p_i            = int'(degree_q);
		kc_i           = int'(knot_count_q);
		stat.cfg_bad   = (p_i < 1) || (p_i > MAX_DEGREE) || (kc_i < 2 * p_i + 2) ||
			(kc_i > MAX_KNOTS);
		stat.u_lt      = u_q < rd_q;
		stat.u_gt      = u_q > rd_q;
		stat.u_eq      = u_q == rd_q;
		stat.srch_done = (hi_q - lo_q) < IW'(2);
		stat.r_last    = (r_q + JW'(1)) == j_q;
		stat.j_last    = j_q == JW'(degree_q);
		stat.k_last    = k_q == JW'(degree_q);
		stat.div_done  = div_done;
	end

endmodule

[hw/rtl/bsp_ctrl.sv]
// Controller state machine: handshakes, span search, basis triangle and
// accumulation sequencing. Drives datapath commands; depends on bsp_pkg.

module bsp_ctrl import bsp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic [OP_W-1:0] item_op,
	output logic            item_ready,
	output logic            res_valid,
	input  logic            res_ready,
	input  dp_stat_t        stat,
	output dp_cmd_t         cmd
);

	ctl_state_t state_q, state_d;
	logic       fail_q, fail_d;
	logic       res_valid_q, res_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fail_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fail_q  <= fail_d;
			if (res_set)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d    = state_q;
		fail_d     = fail_q;
		cmd        = CMD_NONE;
		item_ready = 1'b0;
		res_set    = 1'b0;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd    = CMD_ACCEPT;
					fail_d = 1'b0;
					if (item_op == OP_EVAL)
						state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.cfg_bad) begin
					fail_d  = 1'b1;
					state_d = S_EMIT;
				end else begin
					cmd     = CMD_RD_LO;
					state_d = S_LO;
				end
			end
			S_LO: begin
				if (stat.u_lt) begin
					fail_d  = 1'b1;
					state_d = S_EMIT;
				end else begin
					cmd     = CMD_RD_HI;
					state_d = S_HI;
				end
			end
			S_HI: begin
				if (stat.u_gt) begin
					fail_d  = 1'b1;
					state_d = S_EMIT;
				end else if (stat.u_eq) begin
					cmd     = CMD_SPAN_END;
					state_d = S_BINIT;
				end else begin
					cmd     = CMD_SRCH_INIT;
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (stat.srch_done) begin
					cmd     = CMD_SPAN_LO;
					state_d = S_BINIT;
				end else begin
					cmd     = CMD_RD_MID;
					state_d = S_SCMP;
				end
			end
			S_SCMP: begin
				cmd     = CMD_SRCH_UPD;
				state_d = S_SRCH;
			end
			S_BINIT: begin
				cmd     = CMD_BASIS_INIT;
				state_d = S_RDL;
			end
			S_RDL: begin
				cmd     = CMD_RD_LEFT;
				state_d = S_RDR;
			end
			S_RDR: begin
				cmd     = CMD_RD_RIGHT;
				state_d = S_SETR;
			end
			S_SETR: begin
				cmd     = CMD_SET_RIGHT;
				state_d = S_DEN;
			end
			S_DEN: begin
				cmd     = CMD_DEN;
				state_d = S_MULR;
			end
			S_MULR: begin
				cmd     = CMD_MUL_R;
				state_d = S_MULL;
			end
			S_MULL: begin
				cmd     = CMD_MUL_L;
				state_d = S_DIVS;
			end
			S_DIVS: begin
				cmd     = CMD_DIV_START;
				state_d = S_DIVW;
			end
			S_DIVW: begin
				if (stat.div_done) begin
					cmd     = CMD_NB_UPD;
					state_d = stat.r_last ? S_NBTOP : S_DEN;
				end
			end
			S_NBTOP: begin
				cmd     = CMD_NB_TOP;
				state_d = stat.j_last ? S_MINIT : S_RDL;
			end
			S_MINIT: begin
				cmd     = CMD_MAC_INIT;
				state_d = S_RDPT;
			end
			S_RDPT: begin
				cmd     = CMD_RD_PT;
				state_d = S_MX;
			end
			S_MX: begin
				cmd     = CMD_MAC_X;
				state_d = S_MY;
			end
			S_MY: begin
				cmd     = CMD_MAC_Y;
				state_d = S_MZ;
			end
			S_MZ: begin
				cmd     = CMD_MAC_Z;
				state_d = stat.k_last ? S_EMIT : S_RDPT;
			end
			S_EMIT: begin
				// The result registers are loaded only once the previous word is taken.
				if (!res_valid_q) begin
					cmd     = fail_q ? CMD_FAIL : CMD_FINISH;
					res_set = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign res_valid = res_valid_q;

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result word raised outside the emit state");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVW && !stat.div_done) |=> (state_q == S_DIVW))
		else $error("left division wait before the quotient was ready");

	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_DIV_START) |=> !stat.div_done)
		else $error("divider reported done right after a start");

endmodule

[hw/rtl/bspline_curve_point_evaluator.sv]
// B-spline curve point evaluator. A write word is taken in the cycle it is offered while
// the block is idle. An evaluate word runs the span search, then the basis triangle, each
// cell of which waits on the divider, then the accumulation over the p+1 control points
// for degree p. One word is worked at a time; the next is taken as soon as the previous
// one is done. Asynchronous active-low reset sets degree 3 and 8 knots; the stores are
// undefined until written.

module bspline_curve_point_evaluator import bsp_pkg::*; #(
	parameter int MAX_KNOTS  = DEF_MAX_KNOTS,
	parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bsp_item_if.sink              item,
	bsp_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// The controller sequences the datapath one command per cycle. The datapath
	// reports comparisons and counter ends back through a status struct.
	dp_cmd_t  cmd;
	dp_stat_t stat;

	bsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.op),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// The datapath holds the stores, the search and triangle registers and the
	// result word register, which stays stable while the result waits.
	bsp_dp #(
		.MAX_KNOTS  (MAX_KNOTS),
		.MAX_DEGREE (MAX_DEGREE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (item.op),
		.index      (item.index),
		.knot_value (item.knot_value),
		.point_x    (item.point_x),
		.point_y    (item.point_y),
		.point_z    (item.point_z),
		.param_u    (item.param_u),
		.cmd        (cmd),
		.stat       (stat),
		.status     (result.status),
		.span       (result.span),
		.curve_x    (result.curve_x),
		.curve_y    (result.curve_y),
		.curve_z    (result.curve_z)
	);

endmodule

[tb/bspline_curve_point_evaluator_test.sv]
// Testbench for the B-spline curve point evaluator: loads knot vectors and control
// points, evaluates curve points and checks every result word against its own predictor.
// Depends on bsp_pkg, the channel interfaces in bsp_if and the evaluator top level.

`timescale 1ns / 1ps

module bspline_curve_point_evaluator_test;
	import bsp_pkg::*;

	localparam int  NKNOTS     = DEF_MAX_KNOTS;
	localparam int  NDEG       = DEF_MAX_DEGREE;
	localparam int  ITEM_GOAL  = 1050;
	localparam int  QUIET_FROM = 950;
	localparam int  CYCLE_CAP  = 10000000;
	localparam int  DRAIN      = 2500;
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;  // unused code, dropped by the block

	// One curve point word as the result channel carries it.
	typedef struct {
		logic                      status;
		logic [SPAN_W-1:0]         span;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bsp_item_if   item_ch ();
	bsp_result_if result_ch ();

	bspline_curve_point_evaluator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the block's stores and registers, kept in step with accepted words.
	logic [U_W-1:0]            knot_mem [NKNOTS];
	logic signed [COORD_W-1:0] px_mem   [NKNOTS];
	logic signed [COORD_W-1:0] py_mem   [NKNOTS];
	logic signed [COORD_W-1:0] pz_mem   [NKNOTS];
	int unsigned cur_degree;
	int unsigned cur_knot_count;

	point_word_t pending_points[$];
	int          errors;
	int          words_sent;
	int          hold_cycles;   // long receiver hold-off requested by the pressure test
	bit          quiet;         // no idling on either side when set
	longint      cycles;

	// Clock with a 12 ns period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run-time guard: a hung block must not keep the run alive.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_CAP) begin
				$display("%0t: timeout after %0d cycles", $time, cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Saturation helpers matching the datapath's fixed-point rules.
	function automatic longint sat_basis(longint v);
		if (v < -(64'sd1 <<< 31)) return -(64'sd1 <<< 31);
		if (v > (64'sd1 <<< 31) - 1) return (64'sd1 <<< 31) - 1;
		return v;
	endfunction

	function automatic longint sat_acc(longint v);
		longint lim;
		lim = (64'sd1 <<< 62) - 1;
		if (v < -lim) return -lim;
		if (v > lim) return lim;
		return v;
	endfunction

	// Q.46 accumulator to Q16.16, rounded half up and saturated to 32 bits.
	function automatic logic signed [COORD_W-1:0] round_to_coord(longint acc);
		longint v;
		longint q;
		v = acc + (64'sd1 <<< 29);
		q = v / (64'sd1 <<< 30);
		if ((v % (64'sd1 <<< 30)) != 0 && v < 0) q--;
		q = sat_basis(q);
		return q[COORD_W-1:0];
	endfunction

	function automatic longint safe_div(longint a, longint d);
		return (d == 0) ? 0 : a / d;
	endfunction

	// Expected curve point for parameter u under the current knots, points and registers.
	function automatic point_word_t curve_point_at(logic [U_W-1:0] u_in);
		point_word_t r;
		longint nb [NDEG+1];
		longint lft[NDEG+1];
		longint rgt[NDEG+1];
		longint u, carry, den, tr, tl, ax, ay, az;
		int p, ncp, s, lo, hi, mid, k;
		r.status = 1'b1;
		r.span   = '0;
		r.x      = '0;
		r.y      = '0;
		r.z      = '0;
		p = cur_degree;
		if (p < 1 || p > NDEG || cur_knot_count < 2 * p + 2 || cur_knot_count > NKNOTS)
			return r;
		ncp = cur_knot_count - p - 1;
		u = u_in;
		if (u < longint'(knot_mem[p]) || u > longint'(knot_mem[ncp]))
			return r;
		// The top end of the domain belongs to the last span.
		if (u == longint'(knot_mem[ncp])) begin
			s = ncp - 1;
		end else begin
			lo = p;
			hi = ncp;
			while (hi - lo > 1) begin
				mid = (lo + hi) / 2;
				if (u < longint'(knot_mem[mid])) hi = mid;
				else lo = mid;
			end
			s = lo;
		end
		// Cox-de Boor triangle, seeded with 1.0 in Q2.30.
		nb[0] = 64'sd1 <<< 30;
		for (int j = 1; j <= p; j++) begin
			carry  = 0;
			lft[j] = u - longint'(knot_mem[s + 1 - j]);
			rgt[j] = longint'(knot_mem[s + j]) - u;
			for (int c = 0; c < j; c++) begin
				den   = rgt[c + 1] + lft[j - c];
				tr    = safe_div(rgt[c + 1] * nb[c], den);
				tl    = safe_div(lft[j - c] * nb[c], den);
				nb[c] = sat_basis(carry + tr);
				carry = tl;
			end
			nb[j] = sat_basis(carry);
		end
		ax = 0;
		ay = 0;
		az = 0;
		for (int j = 0; j <= p; j++) begin
			k  = s - p + j;
			ax = sat_acc(ax + sat_acc(nb[j] * longint'(px_mem[k])));
			ay = sat_acc(ay + sat_acc(nb[j] * longint'(py_mem[k])));
			az = sat_acc(az + sat_acc(nb[j] * longint'(pz_mem[k])));
		end
		r.status = 1'b0;
		r.span   = s[SPAN_W-1:0];
		r.x      = round_to_coord(ax);
		r.y      = round_to_coord(ay);
		r.z      = round_to_coord(az);
		return r;
	endfunction

	// Offers one input word and returns once it is accepted. Valid is left high so that
	// a following word can go out back to back; wait_idle lowers it.
	task automatic send_word(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
		logic [U_W-1:0] kv, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
		logic [COORD_W-1:0] z, logic [U_W-1:0] u);
		if (!quiet && $urandom_range(3, 0) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.op         <= op;
		item_ch.index      <= idx;
		item_ch.knot_value <= kv;
		item_ch.point_x    <= x;
		item_ch.point_y    <= y;
		item_ch.point_z    <= z;
		item_ch.param_u    <= u;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		words_sent++;
		// The word is in; bring the shadow state up to date and note any result it causes.
		case (op)
			OP_KNOT: knot_mem[idx] = kv;
			OP_POINT: begin
				px_mem[idx] = x;
				py_mem[idx] = y;
				pz_mem[idx] = z;
			end
			OP_EVAL: pending_points.push_back(curve_point_at(u));
			default: ;
		endcase
	endtask

	task automatic send_knot(int idx, logic [U_W-1:0] kv);
		send_word(OP_KNOT, idx[INDEX_W-1:0], kv, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic send_point(int idx, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
		logic [COORD_W-1:0] z);
		send_word(OP_POINT, idx[INDEX_W-1:0], $urandom, x, y, z, $urandom);
	endtask

	task automatic send_eval(logic [U_W-1:0] u);
		send_word(OP_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom, u);
	endtask

	// Lowers valid and waits until every expected point word has come back, plus a margin
	// that covers a write word still being taken in.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_points.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DEGREE) cur_degree = value & 32'h7;
		else cur_knot_count = value & 32'h7F;
	endtask

	task automatic configure(int unsigned deg, int unsigned kc);
		wait_idle();
		write_reg(CFG_DEGREE, deg);
		write_reg(CFG_KNOT_COUNT, kc);
	endtask

	// Loads a knot vector for the current registers. Nondecreasing with repeats and, on a
	// random choice, clamped ends; when noisy, knots are fully random and may go down.
	task automatic load_knots(bit noisy);
		int unsigned kc, p, smax;
		longint v;
		bit clamp;
		kc    = (cur_knot_count > NKNOTS) ? NKNOTS : cur_knot_count;
		p     = cur_degree;
		clamp = $urandom_range(1, 0);
		smax  = ($urandom_range(2, 0) == 0) ? 8 : (24'hFFFFFF / (kc + 1));
		v     = $urandom_range(smax, 0);
		for (int i = 0; i < kc; i++) begin
			if (i > 0 && !(clamp && (i <= p || i >= kc - p)) && $urandom_range(4, 0) != 0)
				v += $urandom_range(smax, 1);
			if (v > 24'hFFFFFF) v = 24'hFFFFFF;
			if (noisy) send_knot(i, $urandom);
			else send_knot(i, v[U_W-1:0]);
		end
	endtask

	function automatic logic [COORD_W-1:0] random_coord();
		case ($urandom_range(5, 0))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(32'h0008_0000, 0) - 32'h0004_0000;
			default: return $urandom;
		endcase
	endfunction

	// Parameter mostly inside the domain, with its ends, knot values and strays mixed in.
	function automatic logic [U_W-1:0] random_param();
		int unsigned lo, hi, p, ncp;
		p = cur_degree;
		if (p < 1 || cur_knot_count < 2 * p + 2 || cur_knot_count > NKNOTS)
			return $urandom;
		ncp = cur_knot_count - p - 1;
		lo  = knot_mem[p];
		hi  = knot_mem[ncp];
		if (lo > hi) return $urandom;
		case ($urandom_range(9, 0))
			0: return lo[U_W-1:0];
			1: return hi[U_W-1:0];
			2: return knot_mem[$urandom_range(ncp, p)];
			3: return (lo == 0) ? 24'hFFFFFF : lo[U_W-1:0] - 1;
			4: return (hi == 24'hFFFFFF) ? 24'h0 : hi[U_W-1:0] + 1;
			5: return $urandom;
			default: return lo + $urandom_range(hi - lo, 0);
		endcase
	endfunction

	// Receiver: drives ready with random stalls or a requested long hold-off, and checks
	// each accepted point word against the oldest expectation.
	initial begin
		int burst;
		logic next_ready;
		point_word_t want;
		burst = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				if (pending_points.size() == 0) begin
					errors++;
					$display("%0t: unexpected point word: expected none, actual %0d/%0d/%h/%h/%h",
						$time, result_ch.status, result_ch.span, result_ch.curve_x,
						result_ch.curve_y, result_ch.curve_z);
				end else begin
					want = pending_points.pop_front();
					if (result_ch.status !== want.status) begin
						errors++;
						$display("%0t: status: expected %0d, actual %0d", $time,
							want.status, result_ch.status);
					end
					if (result_ch.span !== want.span) begin
						errors++;
						$display("%0t: span: expected %0d, actual %0d", $time,
							want.span, result_ch.span);
					end
					if (result_ch.curve_x !== want.x) begin
						errors++;
						$display("%0t: curve_x: expected %h, actual %h", $time,
							want.x, result_ch.curve_x);
					end
					if (result_ch.curve_y !== want.y) begin
						errors++;
						$display("%0t: curve_y: expected %h, actual %h", $time,
							want.y, result_ch.curve_y);
					end
					if (result_ch.curve_z !== want.z) begin
						errors++;
						$display("%0t: curve_z: expected %h, actual %h", $time,
							want.z, result_ch.curve_z);
					end
				end
			end
			// Only one ready assignment per edge.
			if (hold_cycles > 0) begin
				hold_cycles--;
				next_ready = 1'b0;
			end else if (quiet) begin
				next_ready = 1'b1;
			end else if (burst > 0) begin
				burst--;
				next_ready = 1'b0;
			end else if ($urandom_range(4, 0) == 0) begin
				burst = $urandom_range(4, 1) - 1;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			result_ch.ready <= next_ready;
		end
	end

	// Every slot of every store is written first, so that no evaluation ever reads an
	// entry that was never loaded.
	task automatic test_fill_stores();
		for (int i = 0; i < NKNOTS; i++) send_knot(i, i * 24'h1_0000);
		for (int i = 0; i < NKNOTS; i++) send_point(i, random_coord(), random_coord(),
			random_coord());
	endtask

	// Directed cases at the reset registers and at the extremes of the registers.
	task automatic test_directed();
		// Reset registers: degree 3 with 8 knots, domain is knot 3 to knot 4.
		send_eval(24'h03_0000);          // lower end of the domain
		send_eval(24'h04_0000);          // upper end, goes to the last span
		send_eval(24'h03_8000);          // halfway, the 0.5 point
		send_eval(24'h02_FFFF);          // just below the domain
		send_eval(24'h04_0001);          // just above the domain
		send_eval(24'hFF_FFFF);
		send_word(OP_NOP, 6'h3F, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			24'hFFFFFF);
		// Extreme coordinates drive the accumulator and the output into saturation.
		send_point(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_point(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_eval(24'h03_4000);
		// Repeated knots give zero denominators in the triangle.
		send_knot(4, 24'h03_0000);
		send_knot(5, 24'h03_0000);
		send_eval(24'h03_0000);
		// Degree 1 with the smallest knot count.
		configure(1, 4);
		send_knot(3, 24'hFF_FFFF);
		send_eval(24'h80_0000);
		send_eval(24'hFF_FFFF);
		// Highest degree with the full store.
		configure(NDEG, NKNOTS);
		send_eval(24'h07_0000);
		send_eval(24'h38_0000);
		send_eval(24'h1F_8000);
		// Invalid registers: degree zero, too few knots, too many knots.
		configure(0, 8);
		send_eval(24'h01_0000);
		configure(3, 7);
		send_eval(24'h03_8000);
		configure(3, 127);
		send_eval(24'h03_8000);
	endtask

	// The receiver holds off for a long stretch while evaluations keep coming, so the
	// block fills up and holds its input.
	task automatic test_result_holdoff();
		configure(2, 10);
		load_knots(1'b0);
		hold_cycles = 4000;
		repeat (6) send_eval(random_param());
	endtask

	// Random curves: register changes, knot vectors, point updates and evaluations.
	task automatic test_random_curves();
		int unsigned deg, kc, roll;
		while (words_sent < ITEM_GOAL) begin
			if (words_sent >= QUIET_FROM) quiet = 1'b1;
			roll = $urandom_range(19, 0);
			if (roll == 0) deg = NDEG;
			else if (roll == 1) deg = $urandom_range(6, 4);
			else deg = $urandom_range(3, 1);
			kc = $urandom_range(NKNOTS < 2 * deg + 12 ? NKNOTS : 2 * deg + 12, 2 * deg + 2);
			if ($urandom_range(9, 0) == 0) kc = NKNOTS;
			if ($urandom_range(14, 0) == 0) begin
				// Broken registers: degree zero or a knot count out of range.
				if ($urandom_range(1, 0)) deg = 0;
				else kc = $urandom_range(1, 0) ? $urandom_range(2 * deg + 1, 0) :
					$urandom_range(127, NKNOTS + 1);
			end
			configure(deg, kc);
			if ($urandom_range(9, 0) != 0) load_knots($urandom_range(7, 0) == 0);
			repeat ($urandom_range(12, 4)) begin
				roll = $urandom_range(9, 0);
				if (roll < 3)
					send_point($urandom_range(NKNOTS - 1, 0), random_coord(), random_coord(),
						random_coord());
				else if (roll == 3)
					send_word(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom);
				else
					send_eval(random_param());
			end
		end
	endtask

	initial begin
		errors         = 0;
		words_sent     = 0;
		hold_cycles    = 0;
		quiet          = 1'b0;
		cur_degree     = 3;
		cur_knot_count = 8;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= '0;
		cfg_data           <= '0;
		item_ch.valid      <= 1'b0;
		item_ch.op         <= OP_KNOT;
		item_ch.index      <= '0;
		item_ch.knot_value <= '0;
		item_ch.point_x    <= '0;
		item_ch.point_y    <= '0;
		item_ch.point_z    <= '0;
		item_ch.param_u    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_stores();
		test_directed();
		test_result_holdoff();
		test_random_curves();

		// Drain, then allow for a full evaluation at the highest degree.
		wait_idle();
		repeat (DRAIN) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/bsp_pkg.sv
hw/rtl/bsp_if.sv
hw/rtl/bsp_div.sv
hw/rtl/bsp_dp.sv
hw/rtl/bsp_ctrl.sv
hw/rtl/bspline_curve_point_evaluator.sv
tb/bspline_curve_point_evaluator_test.sv
